>>> rtl/core/plp_pkg.sv
package plp_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned PctW   = 7;
  localparam int unsigned CountW = 8;

  localparam logic [ByteW-1:0]  CH_CR    = 8'h0D;
  localparam logic [ByteW-1:0]  CH_LF    = 8'h0A;
  localparam logic [ByteW-1:0]  CH_ZERO  = 8'h30;
  localparam logic [ByteW-1:0]  CH_NINE  = 8'h39;
  localparam logic [ByteW-1:0]  CH_PLUS  = 8'h2B;
  localparam logic [ByteW-1:0]  CH_MINUS = 8'h2D;

  localparam logic [PctW-1:0]   PCT_MAX   = 7'd100;
  localparam logic [PctW-1:0]   PCT_TEN   = 7'd10;
  localparam logic [CountW-1:0] COUNT_MAX = 8'd255;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_NUMBER  = 3'd1,
    MODE_PLUS    = 3'd2,
    MODE_MINUS   = 3'd3,
    MODE_INVALID = 3'd4
  } plp_mode_t;

  typedef struct packed {
    logic              line_valid;
    logic [PctW-1:0]   percent_value;
    logic [CountW-1:0] char_count;
  } plp_result_t;

endpackage

>>> rtl/core/plp_ifs.sv
interface plp_in_if;
  logic                      valid;
  logic                      ready;
  logic [plp_pkg::ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface plp_out_if;
  logic                       valid;
  logic                       ready;
  logic                       line_valid;
  logic [plp_pkg::PctW-1:0]   percent_value;
  logic [plp_pkg::CountW-1:0] char_count;

  modport source (output valid, output line_valid, output percent_value,
                  output char_count, input ready);
  modport sink   (input valid, input line_valid, input percent_value,
                  input char_count, output ready);
endinterface

>>> rtl/core/percent_line_parser_core.sv
// channel | dir | payload                                  | transfer
// rx      | in  | rx_byte[7:0]                             | valid & ready
// res     | out | line_valid, percent_value[6:0], char[7:0] | valid & ready
// cfg     | in  | cfg_wdata[6:0] (start_value)              | cfg_we
//
// One byte per cycle unless stalled: byte register, then the per-byte parse
// update into the line state and, on CR/LF, into the result register.
// A terminator waits in the byte register only while the result register is
// full and not being taken; rx.ready then drops. Sync reset clears all control.
module percent_line_parser_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [plp_pkg::PctW-1:0]  cfg_wdata,
  plp_in_if.sink                    rx,
  plp_out_if.source                 res
);
  import plp_pkg::*;

  logic              byte_valid;
  logic [ByteW-1:0]  byte_q;
  logic [PctW-1:0]   start_value;
  plp_mode_t         mode;
  logic [PctW-1:0]   running_value;
  logic [CountW-1:0] chars_seen;

  plp_mode_t         mode_next;
  logic [PctW-1:0]   running_next;
  logic [CountW-1:0] chars_next;
  logic              is_term;
  plp_result_t       result;
  logic              out_free;
  logic              step;

  assign step     = byte_valid && (!is_term || out_free);
  assign rx.ready = !byte_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (rx.ready) begin
      byte_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.ready && rx.valid) begin
      byte_q <= rx.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_value <= '0;
    end else if (cfg_we) begin
      start_value <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_IDLE;
      running_value <= '0;
      chars_seen    <= '0;
    end else if (step) begin
      mode          <= mode_next;
      running_value <= running_next;
      chars_seen    <= chars_next;
    end
  end

  plp_step u_step (
    .mode          (mode),
    .running_value (running_value),
    .chars_seen    (chars_seen),
    .start_value   (start_value),
    .rx_byte       (byte_q),
    .mode_next     (mode_next),
    .running_next  (running_next),
    .chars_next    (chars_next),
    .is_term       (is_term),
    .result        (result)
  );

  plp_out_stage u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (step && is_term),
    .result (result),
    .free   (out_free),
    .res    (res)
  );

endmodule

>>> rtl/core/plp_step.sv
module plp_step (
  input  plp_pkg::plp_mode_t          mode,
  input  logic [plp_pkg::PctW-1:0]    running_value,
  input  logic [plp_pkg::CountW-1:0]  chars_seen,
  input  logic [plp_pkg::PctW-1:0]    start_value,
  input  logic [plp_pkg::ByteW-1:0]   rx_byte,
  output plp_pkg::plp_mode_t          mode_next,
  output logic [plp_pkg::PctW-1:0]    running_next,
  output logic [plp_pkg::CountW-1:0]  chars_next,
  output logic                        is_term,
  output plp_pkg::plp_result_t        result
);
  import plp_pkg::*;

  logic            is_digit;
  logic [PctW-1:0] digit;
  logic [PctW-1:0] times_ten;
  plp_mode_t       eff_mode;
  logic [PctW-1:0] eff_value;

  assign is_term   = (rx_byte == CH_CR) || (rx_byte == CH_LF);
  assign is_digit  = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
  assign digit     = {3'b000, rx_byte[3:0]};
  assign times_ten = {running_value[PctW-4:0], 3'b000} + {running_value[PctW-2:0], 1'b0};

  always_comb begin
    result.line_valid    = (mode != MODE_INVALID);
    result.percent_value = (mode == MODE_IDLE) ? start_value : running_value;
    result.char_count    = chars_seen;

    // first character of a line picks the mode
    eff_mode  = mode;
    eff_value = running_value;
    if (mode == MODE_IDLE) begin
      eff_value = start_value;
      if (is_digit) begin
        eff_mode  = MODE_NUMBER;
        eff_value = '0;
      end else if (rx_byte == CH_PLUS) begin
        eff_mode = MODE_PLUS;
      end else if (rx_byte == CH_MINUS) begin
        eff_mode = MODE_MINUS;
      end else begin
        eff_mode = MODE_INVALID;
      end
    end

    mode_next    = eff_mode;
    running_next = eff_value;
    case (eff_mode)
      MODE_NUMBER: begin
        if (!is_digit) begin
          mode_next = MODE_INVALID;
        end else if (eff_value < PCT_TEN) begin
          running_next = ((mode == MODE_IDLE) ? '0 : times_ten) + digit;
        end else if (eff_value == PCT_TEN && digit == '0) begin
          running_next = PCT_MAX;
        end else begin
          mode_next = MODE_INVALID;
        end
      end
      MODE_PLUS: begin
        if (rx_byte != CH_PLUS) begin
          mode_next = MODE_INVALID;
        end else if (eff_value < PCT_MAX) begin
          running_next = eff_value + 7'd1;
        end
      end
      MODE_MINUS: begin
        if (rx_byte != CH_MINUS) begin
          mode_next = MODE_INVALID;
        end else if (eff_value != '0) begin
          running_next = eff_value - 7'd1;
        end
      end
      default: begin
      end
    endcase

    chars_next = (chars_seen == COUNT_MAX) ? chars_seen : chars_seen + 8'd1;

    if (is_term) begin
      mode_next    = MODE_IDLE;
      running_next = start_value;
      chars_next   = '0;
    end
  end

endmodule

>>> rtl/core/plp_out_stage.sv
module plp_out_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  plp_pkg::plp_result_t result,
  output logic                 free,
  plp_out_if.source            res
);
  import plp_pkg::*;

  logic        valid;
  plp_result_t data;

  assign free = !valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (res.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= result;
    end
  end

  assign res.valid         = valid;
  assign res.line_valid    = data.line_valid;
  assign res.percent_value = data.percent_value;
  assign res.char_count    = data.char_count;

endmodule

>>> rtl/core/plp_checker.sv
module plp_checker (
  input logic       clk,
  input logic       rst,
  input logic       rx_ready,
  input logic       res_valid,
  input logic       res_ready,
  input logic       line_valid,
  input logic [6:0] percent_value,
  input logic [7:0] char_count
);

  // pipeline comes out of reset empty and open
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> (rx_ready && !res_valid))
    else $error("not empty after reset");

  // a line with no characters is a query and always parses
  a_empty_line_ok: assert property (@(posedge clk) disable iff (rst)
    (res_valid && char_count == 8'd0) |-> line_valid)
    else $error("empty line reported invalid");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> res_valid)
    else $error("result dropped while stalled");

  a_res_stable: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=>
      ($stable(line_valid) && $stable(percent_value) && $stable(char_count)))
    else $error("result changed while stalled");

endmodule

bind percent_line_parser_core plp_checker u_plp_checker (
  .clk           (clk),
  .rst           (rst),
  .rx_ready      (rx.ready),
  .res_valid     (res.valid),
  .res_ready     (res.ready),
  .line_valid    (res.line_valid),
  .percent_value (res.percent_value),
  .char_count    (res.char_count)
);
